// File: hdl/tvwp_pkg.sv
// shared types, constants and the pixel color conversion for the vram write port
// no dependencies
`default_nettype none

package tvwp_pkg;

  localparam int unsigned OFF_W       = 16;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  localparam logic [WORD_W-1:0] KEEP_NONE       = 32'h0000_0000;
  localparam logic [WORD_W-1:0] KEEP_UPPER_ONLY = 32'h0000_ffff;
  localparam logic [WORD_W-1:0] KEEP_LOWER_ONLY = 32'hffff_0000;

  localparam int unsigned UPPER_CLEAR_BIT = 31;
  localparam int unsigned LOWER_CLEAR_BIT = 15;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_BANK = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEEP_COLOR  = 1'd1;

  typedef struct packed {
    logic              kind;
    logic [OFF_W-1:0]  word_offset;
    logic [WORD_W-1:0] write_data;
    logic [WORD_W-1:0] keep_mask;
  } tvwp_in_t;

  typedef struct packed {
    logic [WORD_W-1:0] read_data;
    logic              plot;
    logic [8:0]        pixel_x;
    logic [7:0]        pixel_y;
    logic [23:0]       left_pixel;
    logic [23:0]       right_pixel;
  } tvwp_out_t;

  typedef struct packed {
    logic              is_write;
    logic              do_write;
    logic              visible;
    logic [OFF_W-1:0]  off;
    logic [8:0]        pixel_x;
    logic [7:0]        pixel_y;
    logic [WORD_W-1:0] data;
    logic [WORD_W-1:0] keep;
  } tvwp_job_t;

  function automatic logic [23:0] to_color(input logic [14:0] c, input logic deep);
    logic [23:0] res;
    if (deep) begin
      res = {c[4:0], 3'b000, c[9:5], 3'b000, c[14:10], 3'b000};
    end else begin
      res = {9'd0, c};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// File: hdl/transparent_vram_write_port.sv
// top level of the transparent vram write port: config registers, front end, queue, back end
// depends on tvwp_pkg, tvwp_front, tvwp_queue, tvwp_back
//
//   channel   ports                             handshake
//   input     start, busy, in_item              taken when start is high and busy low
//   result    out_strobe, out_item              one cycle per word, cannot be held off
//   config    cfg_we, cfg_index, cfg_data       written when cfg_we is high
//
// the front end is a six-stage pipeline (offset wrap, then x/y by constant division)
// the back end works each word through its memory as a read, then a merge and write,
// and pops no new word from the queue until that word is written; an accepted item passes
// the front stages, the queue, the read, the exec state and the result register to out_strobe
// busy rises when the two-entry queue is full and the front end holds its last stage
// reset clears control only; vram words are undefined until written, no clearing pass
`default_nettype none

module transparent_vram_write_port #(
  parameter int unsigned BANK_WORDS     = 65536,
  parameter int unsigned LINE_WORDS     = 168,
  parameter int unsigned VISIBLE_WIDTH  = 320,
  parameter int unsigned VISIBLE_HEIGHT = 240
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire tvwp_pkg::tvwp_in_t                    in_item,
  output logic                                       out_strobe,
  output tvwp_pkg::tvwp_out_t                        out_item,
  input  wire logic                                  cfg_we,
  input  wire logic [tvwp_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [tvwp_pkg::CFG_DATA_W-1:0]       cfg_data
);

  import tvwp_pkg::*;

  logic      active_bank_r;
  logic      deep_color_r;
  logic      q_push;
  logic      q_full;
  logic      q_pop;
  logic      q_empty;
  tvwp_job_t front_job;
  tvwp_job_t head_job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_bank_r <= 1'b0;
      deep_color_r  <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ACTIVE_BANK: active_bank_r <= cfg_data[0];
        CFG_DEEP_COLOR:  deep_color_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  tvwp_front #(
    .BANK_WORDS     (BANK_WORDS),
    .LINE_WORDS     (LINE_WORDS),
    .VISIBLE_WIDTH  (VISIBLE_WIDTH),
    .VISIBLE_HEIGHT (VISIBLE_HEIGHT)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_item (in_item),
    .busy    (busy),
    .q_push  (q_push),
    .q_job   (front_job),
    .q_full  (q_full)
  );

  tvwp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (front_job),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head_job (head_job)
  );

  tvwp_back #(
    .BANK_WORDS (BANK_WORDS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .active_bank (active_bank_r),
    .deep_color  (deep_color_r),
    .q_empty     (q_empty),
    .head_job    (head_job),
    .q_pop       (q_pop),
    .out_strobe  (out_strobe),
    .out_item    (out_item)
  );

endmodule

`default_nettype wire

// File: hdl/tvwp_cdiv.sv
// divide by a constant: reciprocal multiply, back multiply, one correction step
// three register stages advanced by en; no package needed
`default_nettype none

module tvwp_cdiv #(
  parameter int unsigned DIVISOR = 168,
  parameter int unsigned N_W     = 16
) (
  input  wire logic           clk,
  input  wire logic           en,
  input  wire logic [N_W-1:0] num,
  output logic      [N_W-1:0] quo,
  output logic      [N_W-1:0] rem
);

  localparam int unsigned DW = $clog2(DIVISOR);
  localparam int unsigned SH = N_W + DW;
  localparam int unsigned MW = N_W + 1;
  localparam int unsigned PW = N_W + MW;
  localparam int unsigned EW = N_W + DW + 2;
  localparam longint unsigned RECIP = (64'd1 << SH) / DIVISOR;

  logic [N_W-1:0] num1_r;
  logic [PW-1:0]  prod_r;
  logic [N_W-1:0] num2_r;
  logic [N_W-1:0] q0_r;
  logic [N_W-1:0] t_r;
  logic [N_W-1:0] quo_r;
  logic [N_W-1:0] rem_r;

  logic [N_W-1:0] q0;
  logic [EW-1:0]  diff;
  logic           fix;

  assign q0   = N_W'(prod_r >> SH);
  assign diff = EW'(num2_r) - EW'(t_r);
  assign fix  = diff >= EW'(DIVISOR);

  always_ff @(posedge clk) begin
    if (en) begin
      num1_r <= num;
      prod_r <= PW'(num) * PW'(RECIP);
      num2_r <= num1_r;
      q0_r   <= q0;
      t_r    <= N_W'(64'(q0) * 64'(DIVISOR));
      quo_r  <= fix ? q0_r + N_W'(1) : q0_r;
      rem_r  <= fix ? N_W'(diff - EW'(DIVISOR)) : N_W'(diff);
    end
  end

  assign quo = quo_r;
  assign rem = rem_r;

endmodule

`default_nettype wire

// File: hdl/tvwp_front.sv
// front end: accepts items, classifies writes, wraps the offset and maps it to x and y
// depends on tvwp_pkg and tvwp_cdiv
`default_nettype none

module tvwp_front #(
  parameter int unsigned BANK_WORDS     = 65536,
  parameter int unsigned LINE_WORDS     = 168,
  parameter int unsigned VISIBLE_WIDTH  = 320,
  parameter int unsigned VISIBLE_HEIGHT = 240
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire tvwp_pkg::tvwp_in_t  in_item,
  output logic                     busy,
  output logic                     q_push,
  output tvwp_pkg::tvwp_job_t      q_job,
  input  wire logic                q_full
);

  import tvwp_pkg::*;

  localparam int unsigned STAGES = 6;
  localparam int unsigned HALF_W = VISIBLE_WIDTH / 2;

  logic [STAGES-1:0] v_r;
  tvwp_job_t         side_r [STAGES];

  logic              adv;
  logic              accept;
  tvwp_job_t         in_job;
  tvwp_job_t         mid_job;
  logic [OFF_W-1:0]  bank_rem;
  logic [OFF_W-1:0]  line_quo;
  logic [OFF_W-1:0]  line_rem;
  logic              up_ok;
  logic              lo_ok;

  assign adv    = !(v_r[STAGES-1] && q_full);
  assign busy   = !adv;
  assign accept = start && adv;
  assign q_push = v_r[STAGES-1] && !q_full;

  // write classification
  always_comb begin
    up_ok          = !in_item.write_data[UPPER_CLEAR_BIT];
    lo_ok          = !in_item.write_data[LOWER_CLEAR_BIT];
    in_job         = '0;
    in_job.is_write = in_item.kind == KIND_WRITE;
    in_job.data    = in_item.write_data;
    in_job.keep    = in_item.keep_mask;
    if (in_item.keep_mask == KEEP_NONE) begin
      in_job.do_write = up_ok || lo_ok;
      in_job.keep     = {{16{!up_ok}}, {16{!lo_ok}}};
    end else if (in_item.keep_mask == KEEP_UPPER_ONLY) begin
      in_job.do_write = up_ok;
    end else if (in_item.keep_mask == KEEP_LOWER_ONLY) begin
      in_job.do_write = lo_ok;
    end else begin
      in_job.do_write = 1'b1;
    end
    if (in_item.kind == KIND_READ) begin
      in_job.do_write = 1'b0;
    end
  end

  tvwp_cdiv #(
    .DIVISOR (BANK_WORDS),
    .N_W     (OFF_W)
  ) u_bank_div (
    .clk (clk),
    .en  (adv),
    .num (in_item.word_offset),
    .quo (),
    .rem (bank_rem)
  );

  tvwp_cdiv #(
    .DIVISOR (LINE_WORDS),
    .N_W     (OFF_W)
  ) u_line_div (
    .clk (clk),
    .en  (adv),
    .num (bank_rem),
    .quo (line_quo),
    .rem (line_rem)
  );

  always_comb begin
    mid_job     = side_r[2];
    mid_job.off = bank_rem;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[STAGES-2:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= in_job;
      side_r[1] <= side_r[0];
      side_r[2] <= side_r[1];
      side_r[3] <= mid_job;
      side_r[4] <= side_r[3];
      side_r[5] <= side_r[4];
    end
  end

  always_comb begin
    q_job         = side_r[STAGES-1];
    q_job.visible = (32'(line_rem) < 32'(HALF_W)) && (32'(line_quo) < 32'(VISIBLE_HEIGHT));
    q_job.pixel_x = {line_rem[7:0], 1'b0};
    q_job.pixel_y = line_quo[7:0];
  end

endmodule

`default_nettype wire

// File: hdl/tvwp_queue.sv
// two-entry job queue between the front end and the memory back end
// depends on tvwp_pkg
`default_nettype none

module tvwp_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire tvwp_pkg::tvwp_job_t  push_job,
  output logic                      full,
  input  wire logic                 pop,
  output logic                      empty,
  output tvwp_pkg::tvwp_job_t       head_job
);

  import tvwp_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  tvwp_job_t        slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  logic do_push;
  logic do_pop;

  assign full     = count_r == CNT_W'(QUEUE_DEPTH);
  assign empty    = count_r == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_job = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (32'(wr_ptr_r) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (32'(rd_ptr_r) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

// File: hdl/tvwp_back.sv
// back end: vram memory, read-modify-write merge and result register
// depends on tvwp_pkg
`default_nettype none

module tvwp_back #(
  parameter int unsigned BANK_WORDS = 65536
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 active_bank,
  input  wire logic                 deep_color,
  input  wire logic                 q_empty,
  input  wire tvwp_pkg::tvwp_job_t  head_job,
  output logic                      q_pop,
  output logic                      out_strobe,
  output tvwp_pkg::tvwp_out_t       out_item
);

  import tvwp_pkg::*;

  localparam int unsigned DEPTH = 2 * BANK_WORDS;
  localparam int unsigned AW    = $clog2(DEPTH);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic [WORD_W-1:0] mem [DEPTH];

  logic              state_r;
  logic              state_nxt;
  tvwp_job_t         job_r;
  logic [AW-1:0]     addr_r;
  logic [WORD_W-1:0] rdata_r;
  logic              out_valid_r;
  tvwp_out_t         out_r;

  logic [AW-1:0]     rd_addr;
  logic [WORD_W-1:0] merged;
  logic              mem_we;
  tvwp_out_t         res;

  assign rd_addr = active_bank ? AW'(head_job.off) + AW'(BANK_WORDS) : AW'(head_job.off);
  assign q_pop   = (state_r == S_IDLE) && !q_empty;
  assign merged  = (rdata_r & job_r.keep) | (job_r.data & ~job_r.keep);
  assign mem_we  = (state_r == S_EXEC) && job_r.do_write;

  always_comb begin
    case (state_r)
      S_IDLE:  state_nxt = q_empty ? S_IDLE : S_EXEC;
      S_EXEC:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    res = '0;
    if (!job_r.is_write) begin
      res.read_data = rdata_r;
    end else if (job_r.do_write && job_r.visible) begin
      res.plot        = 1'b1;
      res.pixel_x     = job_r.pixel_x;
      res.pixel_y     = job_r.pixel_y;
      res.left_pixel  = to_color(merged[30:16], deep_color);
      res.right_pixel = to_color(merged[14:0], deep_color);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr_r] <= merged;
    end
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= state_r == S_EXEC;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r  <= head_job;
      addr_r <= rd_addr;
    end
    if (state_r == S_EXEC) begin
      out_r <= res;
    end
  end

  assign out_strobe = out_valid_r;
  assign out_item   = out_r;

endmodule

`default_nettype wire
